[src/sra_pkg.sv]
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants of the segmented row argsort block
// Defaults for the block parameters, register map, sequencer states and the
// control word that the sequencer hands to the sorting cells.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int ROW_MAX_DEF    = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed widths of the stream fields and registers
	localparam int VALUE_W  = 32;
	localparam int TAG_W    = 32;
	localparam int ROWLEN_W = 7;

	// configuration port
	localparam int APB_DW = 32;
	localparam int ADDR_W = 3;

	localparam logic REG_DESCENDING = 1'b0;
	localparam logic REG_ROW_LENGTH = 1'b1;

	localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST = 7'd64;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                descending;
		logic [ROWLEN_W-1:0] row_length;
	} cfg_t;

	typedef struct packed {
		logic load;        // insert the broadcast word into the chain
		logic shift;       // move the chain one cell toward the head
		logic descending;
	} cell_ctl_t;

endpackage

[src/sra_if.sv]
// ----------------------------------------------------------------------------
// sra_if: stream channels of the segmented row argsort block
// Input channel carries one element, output channel one sorted result.
// ----------------------------------------------------------------------------
interface sra_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [sra_pkg::VALUE_W-1:0]  value_in;
	logic        [sra_pkg::TAG_W-1:0]    tag_in;

	modport source (output valid, output value_in, output tag_in, input ready);
	modport sink   (input valid, input value_in, input tag_in, output ready);
endinterface

interface sra_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [sra_pkg::VALUE_W-1:0]  value_out;
	logic        [sra_pkg::TAG_W-1:0]    tag_out;
	logic                                last;

	modport source (output valid, output value_out, output tag_out, output last,
		input ready);
	modport sink   (input valid, input value_out, input tag_out, input last,
		output ready);
endinterface

[src/sra_cfg.sv]
// ----------------------------------------------------------------------------
// sra_cfg: configuration registers
// APB-style register file holding the sort direction and the row length.
// ----------------------------------------------------------------------------
module sra_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sra_pkg::ADDR_W-1:0]    paddr,
	input  logic [sra_pkg::APB_DW-1:0]    pwdata,
	output logic [sra_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output sra_pkg::cfg_t                 cfg
);

	sra_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic          reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[sra_pkg::ADDR_W-1];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.descending <= 1'b0;
			cfg_q.row_length <= sra_pkg::ROW_LENGTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				sra_pkg::REG_DESCENDING: cfg_q.descending <= pwdata[0];
				sra_pkg::REG_ROW_LENGTH: cfg_q.row_length <= pwdata[sra_pkg::ROWLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			sra_pkg::REG_DESCENDING: prdata[0] = cfg_q.descending;
			sra_pkg::REG_ROW_LENGTH: prdata[sra_pkg::ROWLEN_W-1:0] = cfg_q.row_length;
			default: ;
		endcase
	end

endmodule

[src/sra_cell.sv]
// ----------------------------------------------------------------------------
// sra_cell: one cell of the insertion sorting chain
// Holds one key and tag. On insert it compares the broadcast key with its
// own and either keeps its word, takes the new word or takes its left
// neighbor's word. On drain it takes its right neighbor's word.
// ----------------------------------------------------------------------------
module sra_cell #(
	parameter int KEY_W = sra_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sra_pkg::cell_ctl_t          ctl,
	input  logic signed [KEY_W-1:0]     new_key,
	input  logic [sra_pkg::TAG_W-1:0]   new_tag,
	input  logic                        left_valid,
	input  logic signed [KEY_W-1:0]     left_key,
	input  logic [sra_pkg::TAG_W-1:0]   left_tag,
	input  logic                        left_gt,
	input  logic                        right_valid,
	input  logic signed [KEY_W-1:0]     right_key,
	input  logic [sra_pkg::TAG_W-1:0]   right_tag,
	output logic                        valid,
	output logic signed [KEY_W-1:0]     key,
	output logic [sra_pkg::TAG_W-1:0]   tag,
	output logic                        gt
);

	logic                      valid_q;
	logic signed [KEY_W-1:0]   key_q;
	logic [sra_pkg::TAG_W-1:0] tag_q;
	logic                      new_first;

	// strict compare keeps equal keys in arrival order
	assign new_first = ctl.descending ? (new_key > key_q) : (new_key < key_q);
	assign gt        = !valid_q || new_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right_valid;
		end else if (ctl.load && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctl.load && gt) begin
			key_q <= left_gt ? left_key : new_key;
			tag_q <= left_gt ? left_tag : new_tag;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

endmodule

[src/segmented_row_argsort_top.sv]
// Segmented row argsort. Elements are taken one per cycle while a row is
// being collected; each is inserted into a chain of ROW_MAX sorting cells in
// the cycle it arrives, the cells comparing it with their own keys in
// parallel and shifting the part of the chain that sorts after it by one
// place. When the element that completes the row (row_length, 0 counted as
// 1, capped at ROW_MAX) is taken, the chain drains from its head one result
// per cycle while the output is not stalled, the final one marked last. A
// row of n elements is thus taken in full before any of its n results
// leave, the drain being set by the single head cell of the chain and any
// output stall. Input is not accepted while a row drains. Keys compare as
// signed values of min(DATA_WIDTH, 32) bits and leave sign-extended to 32
// bits; equal keys keep arrival order.
// ----------------------------------------------------------------------------
// segmented_row_argsort_top: top level of the segmented row argsort block
// Configuration registers, row sequencer and the chain of sorting cells.
// ----------------------------------------------------------------------------
module segmented_row_argsort_top #(
	parameter int ROW_MAX    = sra_pkg::ROW_MAX_DEF,
	parameter int DATA_WIDTH = sra_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sra_in_if.sink                        in_stream,
	sra_out_if.source                     out_stream,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sra_pkg::ADDR_W-1:0]    paddr,
	input  logic [sra_pkg::APB_DW-1:0]    pwdata,
	output logic [sra_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int KEY_W  = (DATA_WIDTH < sra_pkg::VALUE_W) ? DATA_WIDTH : sra_pkg::VALUE_W;
	localparam int FILL_W = $clog2(ROW_MAX + 1);
	localparam int CMP_W  = ((FILL_W > sra_pkg::ROWLEN_W) ? FILL_W : sra_pkg::ROWLEN_W) + 1;

	sra_pkg::cfg_t      cfg;
	sra_pkg::state_t    state_q, state_nxt;
	sra_pkg::cell_ctl_t ctl;

	logic [FILL_W-1:0]  fill_q;
	logic [CMP_W-1:0]   len_eff;
	logic [CMP_W-1:0]   fill_next;
	logic               in_acc;
	logic               out_acc;
	logic               row_done;

	logic                      cell_valid [ROW_MAX];
	logic signed [KEY_W-1:0]   cell_key   [ROW_MAX];
	logic [sra_pkg::TAG_W-1:0] cell_tag   [ROW_MAX];
	logic                      cell_gt    [ROW_MAX];
	logic signed [KEY_W-1:0]   new_key;

	sra_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		priority if (cfg.row_length == '0) begin
			len_eff = CMP_W'(1);
		end else if (CMP_W'(cfg.row_length) > CMP_W'(ROW_MAX)) begin
			len_eff = CMP_W'(ROW_MAX);
		end else begin
			len_eff = CMP_W'(cfg.row_length);
		end
	end

	assign in_acc    = in_stream.valid && in_stream.ready;
	assign out_acc   = out_stream.valid && out_stream.ready;
	assign fill_next = CMP_W'(fill_q) + CMP_W'(1);
	assign row_done  = fill_next >= len_eff;
	assign new_key   = in_stream.value_in[KEY_W-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sra_pkg::ST_LOAD:  if (in_acc && row_done) state_nxt = sra_pkg::ST_DRAIN;
			sra_pkg::ST_DRAIN: if (out_acc && out_stream.last) state_nxt = sra_pkg::ST_LOAD;
			default:           state_nxt = sra_pkg::ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stream.ready  = 1'b0;
		out_stream.valid = 1'b0;
		unique case (state_q)
			sra_pkg::ST_LOAD:  in_stream.ready  = 1'b1;
			sra_pkg::ST_DRAIN: out_stream.valid = 1'b1;
			default: ;
		endcase
		ctl.load       = in_acc;
		ctl.shift      = out_acc;
		ctl.descending = cfg.descending;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sra_pkg::ST_LOAD;
			fill_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				fill_q <= row_done ? '0 : fill_next[FILL_W-1:0];
			end
		end
	end

	for (genvar i = 0; i < ROW_MAX; i++) begin : g_cell
		logic                      lv, rv, lg;
		logic signed [KEY_W-1:0]   lk, rk;
		logic [sra_pkg::TAG_W-1:0] lt, rt;

		if (i == 0) begin : g_head
			assign lv = 1'b0;
			assign lk = '0;
			assign lt = '0;
			assign lg = 1'b0;
		end else begin : g_body
			assign lv = cell_valid[i-1];
			assign lk = cell_key[i-1];
			assign lt = cell_tag[i-1];
			assign lg = cell_gt[i-1];
		end

		if (i == ROW_MAX - 1) begin : g_tail
			assign rv = 1'b0;
			assign rk = '0;
			assign rt = '0;
		end else begin : g_inner
			assign rv = cell_valid[i+1];
			assign rk = cell_key[i+1];
			assign rt = cell_tag[i+1];
		end

		sra_cell #(
			.KEY_W (KEY_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_key     (new_key),
			.new_tag     (in_stream.tag_in),
			.left_valid  (lv),
			.left_key    (lk),
			.left_tag    (lt),
			.left_gt     (lg),
			.right_valid (rv),
			.right_key   (rk),
			.right_tag   (rt),
			.valid       (cell_valid[i]),
			.key         (cell_key[i]),
			.tag         (cell_tag[i]),
			.gt          (cell_gt[i])
		);
	end

	// head cell is the output register
	assign out_stream.value_out = sra_pkg::VALUE_W'(cell_key[0]);
	assign out_stream.tag_out   = cell_tag[0];
	assign out_stream.last      = !cell_valid[1];

`ifndef ASSERT_OFF
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_stream.valid |-> cell_valid[0])
		else $error("word offered from an empty head cell");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_stream.ready && out_stream.valid))
		else $error("loading and draining at once");

	a_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_stream.last) |=> (!cell_valid[0] && fill_q == '0))
		else $error("chain not empty after last word of a row");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) < CMP_W'(ROW_MAX))
		else $error("fill count beyond chain length");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && fill_q == '0) |-> !cell_valid[0])
		else $error("new row starts on an occupied chain");
`endif

endmodule
